FILE: rtl/utf8_codepoint_decoder_assert.svh
// Assertion macros shared by the UTF-8 decoder modules
`ifndef UTF8_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UTF8CD_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define UTF8CD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/utf8cd_pkg.sv
// Shared types and constants of the UTF-8 code point decoder
`default_nettype none

package utf8cd_pkg;

    localparam int unsigned CP_W = 21;
    localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;

    // count-1 replacements precede cp; cp is the final result of the beat
    typedef struct packed {
        logic [2:0]      count;
        logic [CP_W-1:0] cp;
        logic            str_end;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/utf8cd_decode.sv
// Sequence state and single-pass decode of one input byte
`default_nettype none

`include "utf8_codepoint_decoder_assert.svh"

module utf8cd_decode
    import utf8cd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_str_end,
    output t_result         o_result
);

    typedef struct packed {
        logic            hit;
        logic [CP_W-1:0] cp;
        logic [1:0]      need;
        logic [4:0]      bits;
    } t_lead;

    function automatic t_lead lead_decode(input logic [7:0] b, input logic last);
        t_lead l;
        l = '0;
        if (b[7] == 1'b0) begin
            l.hit = 1'b1;
            l.cp  = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
            l.need = 2'd1;
            l.bits = b[4:0];
        end else if (b[7:4] == 4'b1110) begin
            l.need = 2'd2;
            l.bits = {1'b0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            l.need = 2'd3;
            l.bits = {2'b00, b[2:0]};
        end else begin
            l.hit = 1'b1;
            l.cp  = CP_REPL;
        end
        if (!l.hit && last) begin
            l.hit  = 1'b1;
            l.cp   = CP_REPL;
            l.need = 2'd0;
        end
        return l;
    endfunction

    logic [1:0]      r_need, n_need;
    logic [1:0]      r_taken, n_taken;
    logic [CP_W-1:0] r_partial, n_partial;

    always_comb begin
        t_lead           lead;
        logic [1:0]      t;
        logic [CP_W-1:0] p;
        lead = lead_decode(i_byte, i_str_end);
        t    = r_taken + 2'd1;
        p    = {r_partial[CP_W-7:0], i_byte[5:0]};

        o_result.str_end = i_str_end;
        o_result.count   = 3'd0;
        o_result.cp      = CP_REPL;
        n_need           = 2'd0;
        n_taken          = 2'd0;
        n_partial        = '0;

        if (r_need == 2'd0) begin
            o_result.count = {2'b00, lead.hit};
            o_result.cp    = lead.cp;
            n_need         = lead.need;
            n_partial      = {16'd0, lead.bits};
        end else if (i_byte[7:6] == 2'b10) begin
            if (t >= r_need) begin
                o_result.count = 3'd1;
                o_result.cp    = p;
            end else if (i_str_end) begin
                o_result.count = {1'b0, t} + 3'd1;
            end else begin
                n_need    = r_need;
                n_taken   = t;
                n_partial = p;
            end
        end else begin
            o_result.count = {1'b0, r_taken} + 3'd1 + {2'b00, lead.hit};
            o_result.cp    = lead.hit ? lead.cp : CP_REPL;
            n_need         = lead.need;
            n_partial      = {16'd0, lead.bits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need    <= 2'd0;
            r_taken   <= 2'd0;
            r_partial <= '0;
        end else if (i_advance) begin
            r_need    <= n_need;
            r_taken   <= n_taken;
            r_partial <= n_partial;
        end
    end

    `UTF8CD_ASSERT_NOW(a_taken_below_need, r_need != 2'd0, r_taken < r_need, "taken reached need")
    `UTF8CD_ASSERT_NOW(a_idle_no_taken, r_need == 2'd0, r_taken == 2'd0, "taken set while closed")
    `UTF8CD_ASSERT_NEXT(a_end_closes, i_advance && i_str_end, r_need == 2'd0, "open after end")

endmodule

`default_nettype wire

FILE: rtl/utf8cd_emit.sv
// Result register that plays out the beats of one decoded byte
`default_nettype none

`include "utf8_codepoint_decoder_assert.svh"

module utf8cd_emit
    import utf8cd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_result    i_result,
    output logic            o_free,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [CP_W-1:0] o_code_point,
    output logic            o_run_last,
    output logic            o_final_of_string
);

    logic [2:0]      r_left;
    logic [CP_W-1:0] r_cp;
    logic            r_end;

    assign o_valid           = r_left != 3'd0;
    assign o_run_last        = r_left == 3'd1;
    assign o_code_point      = o_run_last ? r_cp : CP_REPL;
    assign o_final_of_string = o_run_last && r_end;
    assign o_free            = (r_left == 3'd0) || (o_run_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_load) begin
            r_left <= i_result.count;
        end else if (o_valid && i_ready) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cp  <= i_result.cp;
            r_end <= i_result.str_end;
        end
    end

    `UTF8CD_ASSERT_NOW(a_repl_before_last, o_valid && !o_run_last, o_code_point == CP_REPL, "early beat not U+FFFD")
    `UTF8CD_ASSERT_NOW(a_load_when_free, i_load, o_free && i_result.count != 3'd0, "load into busy stage")
    `UTF8CD_ASSERT_NEXT(a_load_count, i_load, r_left == $past(i_result.count), "beat count lost")

endmodule

`default_nettype wire

FILE: rtl/utf8_codepoint_decoder.sv
// UTF-8 decoder with replacement: top level
//
// Input channel: one raw byte per beat (i_data_byte) with i_string_end high on
// the final byte of a string, handshake i_in_valid / o_in_ready.
// Output channel: one code point per beat, handshake o_out_valid / i_out_ready.
// o_run_last marks the last beat caused by an input byte, o_final_of_string
// the last code point of a string. Bytes that only extend a sequence give no
// beat; a broken or cut-off sequence gives one U+FFFD per byte taken.
// A byte taken in waits in the input register, is decoded and is then loaded
// into the result register, which presents its beats.
// Throughput, while i_out_ready is high: one byte per cycle while each byte
// gives at most one beat; a byte that gives more holds the input until the
// single result register has played its beats out, one per cycle.
// Reset (i_rst_n low, synchronous): no sequence open, both stages empty.
// Stall: while i_out_ready is low the result register holds, one byte waits
// in the input register and o_in_ready drops.
`default_nettype none

module utf8_codepoint_decoder
    import utf8cd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_string_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [CP_W-1:0] o_code_point,
    output logic            o_run_last,
    output logic            o_final_of_string
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       emit_free;
    logic       advance;
    t_result    result;

    assign advance    = r_in_valid && emit_free;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_data_byte;
            r_end  <= i_string_end;
        end
    end

    utf8cd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_byte),
        .i_str_end (r_end),
        .o_result  (result)
    );

    utf8cd_emit u_emit (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (advance && (result.count != 3'd0)),
        .i_result          (result),
        .o_free            (emit_free),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_code_point      (o_code_point),
        .o_run_last        (o_run_last),
        .o_final_of_string (o_final_of_string)
    );

endmodule

`default_nettype wire

FILE: sim/utf8_codepoint_decoder_tb.sv
// Testbench for the UTF-8 code point decoder: directed byte table, then random strings
`timescale 1ns / 1ps

module utf8_codepoint_decoder_tb
    import utf8cd_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 65;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            run_last;
        logic            fin;
    } t_cp_beat;

    typedef struct packed {
        logic [7:0]           data;
        logic                 str_end;
        int                   n;
        logic [3:0][CP_W-1:0] cp;
    } t_stim_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic [7:0]      i_data_byte = 8'h00;
    logic            i_string_end = 1'b0;
    logic            i_out_ready = 1'b0;
    logic            o_in_ready;
    logic            o_out_valid;
    logic [CP_W-1:0] o_code_point;
    logic            o_run_last;
    logic            o_final_of_string;

    logic [1:0]      seq_need = 2'd0;
    logic [1:0]      seq_got = 2'd0;
    logic [CP_W-1:0] seq_bits = '0;
    t_cp_beat        decoded[$];
    t_cp_beat        beats_due[$];

    int src_idle = 0;
    int snk_idle = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int beats_checked = 0;
    int sink_beats = 0;
    int hold_left = 0;
    int cycles = 0;

    utf8_codepoint_decoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_string_end      (i_string_end),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_code_point      (o_code_point),
        .o_run_last        (o_run_last),
        .o_final_of_string (o_final_of_string)
    );

    always #4 i_clk = ~i_clk;

    function automatic void put_cp(logic [CP_W-1:0] cp);
        t_cp_beat b;
        b.cp = cp;
        b.run_last = 1'b0;
        b.fin = 1'b0;
        decoded = {decoded, b};
    endfunction

    function automatic void close_seq();
        seq_need = 2'd0;
        seq_got = 2'd0;
        seq_bits = '0;
    endfunction

    function automatic void open_lead(logic [7:0] b, logic e);
        logic [1:0]      need;
        logic [CP_W-1:0] bits;
        need = 2'd0;
        bits = '0;
        if (b[7] == 1'b0) begin
            put_cp({13'd0, b});
            return;
        end
        if (b[7:5] == 3'b110) begin
            need = 2'd1;
            bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            need = 2'd2;
            bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            need = 2'd3;
            bits = {18'd0, b[2:0]};
        end
        if (need == 2'd0 || e) begin
            put_cp(CP_REPL);
            return;
        end
        seq_need = need;
        seq_got = 2'd0;
        seq_bits = bits;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic e);
        decoded.delete();
        if (seq_need == 2'd0) begin
            open_lead(b, e);
        end else if (b[7:6] == 2'b10) begin
            seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
            seq_got = seq_got + 2'd1;
            if (seq_got >= seq_need) begin
                put_cp(seq_bits);
                close_seq();
            end else if (e) begin
                repeat (int'(seq_got) + 1) put_cp(CP_REPL);
                close_seq();
            end
        end else begin
            repeat (int'(seq_got) + 1) put_cp(CP_REPL);
            close_seq();
            open_lead(b, e);
        end
        if (decoded.size() > 0) begin
            decoded[decoded.size() - 1].run_last = 1'b1;
            decoded[decoded.size() - 1].fin = e;
        end
    endfunction

    function automatic t_stim_row row(logic [7:0] d, logic e, int n = -1,
                                      logic [CP_W-1:0] c0 = '0, logic [CP_W-1:0] c1 = '0,
                                      logic [CP_W-1:0] c2 = '0, logic [CP_W-1:0] c3 = '0);
        t_stim_row r;
        r.data = d;
        r.str_end = e;
        r.n = n;
        r.cp[0] = c0;
        r.cp[1] = c1;
        r.cp[2] = c2;
        r.cp[3] = c3;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_byte(input t_stim_row r);
        t_cp_beat b;
        while ($urandom_range(99) < src_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= r.data;
        i_string_end <= r.str_end;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
        decode_byte(r.data, r.str_end);
        if (r.n < 0) begin
            foreach (decoded[i]) beats_due = {beats_due, decoded[i]};
        end else begin
            for (int i = 0; i < r.n; i++) begin
                b.cp = r.cp[i];
                b.run_last = (i == r.n - 1);
                b.fin = b.run_last & r.str_end;
                beats_due = {beats_due, b};
            end
        end
    endtask

    task automatic send_string();
        logic [7:0] text[$];
        int         nch;
        int         kind;
        int         need;
        int         keep;
        nch = $urandom_range(1, 6);
        repeat (nch) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                text = {text, 8'($urandom_range(127))};
            end else if (kind < 86) begin
                need = (kind < 50) ? 1 : (kind < 65) ? 2 : (kind < 78) ? 3 : $urandom_range(1, 3);
                keep = (kind < 78) ? need : $urandom_range(0, need - 1);
                case (need)
                    1: text = {text, {3'b110, 5'($urandom)}};
                    2: text = {text, {4'b1110, 4'($urandom)}};
                    default: text = {text, {5'b11110, 3'($urandom)}};
                endcase
                repeat (keep) text = {text, {2'b10, 6'($urandom)}};
            end else if (kind < 94) begin
                text = {text, 8'($urandom)};
            end else if (kind < 97) begin
                text = {text, 8'($urandom_range(8'hFF, 8'hF8))};
            end else begin
                text = {text, 8'($urandom_range(8'hBF, 8'h80))};
            end
        end
        foreach (text[i]) send_byte(row(text[i], i == text.size() - 1));
    endtask

    // receiver: random stalls, plus two long hold-offs so the input backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                sink_beats++;
                if (sink_beats == 30 || sink_beats == 160) hold_left = 64;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        t_cp_beat due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (beats_due.size() == 0) begin
                report_mismatch("unexpected beat, code point", o_code_point, 0);
            end else begin
                due = beats_due.pop_front();
                beats_checked++;
                if (o_code_point !== due.cp)
                    report_mismatch("code point", o_code_point, due.cp);
                if (o_run_last !== due.run_last)
                    report_mismatch("run_last", o_run_last, due.run_last);
                if (o_final_of_string !== due.fin)
                    report_mismatch("final_of_string", o_final_of_string, due.fin);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_stim_row table_rows[$];
        int        sent_at;
        table_rows = {table_rows, row(8'h00, 1'b0, 1, 21'h000000)};
        table_rows = {table_rows, row(8'h7F, 1'b1, 1, 21'h00007F)};
        table_rows = {table_rows, row(8'hC2, 1'b0, 0)};
        table_rows = {table_rows, row(8'hA9, 1'b0)};
        table_rows = {table_rows, row(8'hE2, 1'b0)};
        table_rows = {table_rows, row(8'h82, 1'b0)};
        table_rows = {table_rows, row(8'hAC, 1'b0)};
        table_rows = {table_rows, row(8'hF7, 1'b0)};
        table_rows = {table_rows, row(8'hBF, 1'b0)};
        table_rows = {table_rows, row(8'hBF, 1'b0)};
        table_rows = {table_rows, row(8'hBF, 1'b1)};
        table_rows = {table_rows, row(8'h80, 1'b0, 1, CP_REPL)};
        table_rows = {table_rows, row(8'hF8, 1'b0, 1, CP_REPL)};
        table_rows = {table_rows, row(8'hFF, 1'b0, 1, CP_REPL)};
        table_rows = {table_rows, row(8'hF0, 1'b0)};
        table_rows = {table_rows, row(8'h90, 1'b0)};
        table_rows = {table_rows, row(8'h80, 1'b0)};
        table_rows = {table_rows, row(8'h41, 1'b0, 4, CP_REPL, CP_REPL, CP_REPL, 21'h000041)};
        table_rows = {table_rows, row(8'hE2, 1'b0)};
        table_rows = {table_rows, row(8'h82, 1'b1, 2, CP_REPL, CP_REPL)};
        table_rows = {table_rows, row(8'hC3, 1'b1, 1, CP_REPL)};
        table_rows = {table_rows, row(8'hC3, 1'b0)};
        table_rows = {table_rows, row(8'hE2, 1'b0, 1, CP_REPL)};
        table_rows = {table_rows, row(8'h82, 1'b0)};
        table_rows = {table_rows, row(8'hAC, 1'b1)};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle = 33;
        snk_idle = 69;
        foreach (table_rows[i]) send_byte(table_rows[i]);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 33 : (ph == 1) ? 69 : 0;
            snk_idle = (ph == 0) ? 69 : (ph == 1) ? 33 : 0;
            sent_at = bytes_sent;
            while (bytes_sent - sent_at < PHASE_BYTES) send_string();
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (beats_due.size() != 0) @(posedge i_clk);
        end

        repeat (16) @(posedge i_clk);
        $display("Sent %0d bytes (directed table, then random strings under three idling mixes),",
                 bytes_sent);
        $display("checked %0d code point beats, %0d mismatches.", beats_checked, mismatches);
        if (mismatches == 0 && beats_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
